// File: rtl/core/ir_pulse_distance_decoder_assert.svh
// Assertion macros for the IR pulse-distance decoder.
`ifndef IR_PULSE_DISTANCE_DECODER_ASSERT_SVH
`define IR_PULSE_DISTANCE_DECODER_ASSERT_SVH

// Checked on every rising edge of clk, suspended while rst is high.
`define IRPD_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define IRPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/irpd_pkg.sv
// Shared types and constants of the IR pulse-distance decoder.
package irpd_pkg;

  localparam int unsigned StampW = 8;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitPosW = 3;
  localparam int unsigned CountW = 3;
  localparam int unsigned TickW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned OutDataW = 24;

  // register reset values
  localparam logic [ByteW-1:0] OneGapMinRst    = 8'd16;
  localparam logic [ByteW-1:0] OneGapMaxRst    = 8'd18;
  localparam logic [ByteW-1:0] LeaderGapMinRst = 8'd67;
  localparam logic [TickW-1:0] TimeoutTicksRst = 2'd2;

  localparam logic [BitPosW-1:0] BitLast = 3'd7;
  localparam logic [CountW-1:0]  ByteSat = 3'd4;
  localparam logic [CountW-1:0]  AddrByte = 3'd0;
  localparam logic [CountW-1:0]  CmdByte  = 3'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ONE_GAP_MIN    = 2'd0,
    CFG_ONE_GAP_MAX    = 2'd1,
    CFG_LEADER_GAP_MIN = 2'd2,
    CFG_TIMEOUT_TICKS  = 2'd3
  } cfg_index_t;

  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_TICK = 1'b1
  } item_kind_t;

  // result word, address in the lowest bits
  typedef struct packed {
    logic [4:0]        pad;
    logic [CountW-1:0] bytes_seen;
    logic [ByteW-1:0]  frame_command;
    logic [ByteW-1:0]  frame_address;
  } result_t;

endpackage

// File: rtl/core/ir_pulse_distance_decoder.sv
// IR pulse-distance (NEC style) frame decoder: edges and overflow ticks in, frames out.
// A frame result is registered into the output register, or into the skid entry while that register is held.
// Throughput: one request per cycle while the skid entry is empty; the state update is a single registered pass.
// A two-entry output stage (register plus skid) keeps input flowing while a result waits.
// Reset (rst, synchronous, active high): no frame, counters and holds zero,
// registers at 16 / 18 / 67 / 2, output stage empty.
module ir_pulse_distance_decoder (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [irpd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [irpd_pkg::CfgDataW-1:0] cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] timer_stamp
  input  logic        s_axis_tuser,   // [0] cmd: 0 edge, 1 overflow tick
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [irpd_pkg::OutDataW-1:0] m_axis_tdata
  // m_axis_tdata: [7:0] frame_address, [15:8] frame_command, [18:16] bytes_seen, rest zero
);

  // configuration registers
  logic [irpd_pkg::ByteW-1:0] one_gap_min;
  logic [irpd_pkg::ByteW-1:0] one_gap_max;
  logic [irpd_pkg::ByteW-1:0] leader_gap_min;
  logic [irpd_pkg::TickW-1:0] timeout_ticks;

  // decoder state
  logic                          frame_active;
  logic [irpd_pkg::BitPosW-1:0]  bit_position;
  logic [irpd_pkg::CountW-1:0]   byte_count;
  logic [irpd_pkg::ByteW-1:0]    shift_byte;
  logic [irpd_pkg::ByteW-1:0]    address_hold;
  logic [irpd_pkg::ByteW-1:0]    command_hold;
  logic [irpd_pkg::StampW-1:0]   last_stamp;
  logic [irpd_pkg::TickW-1:0]    tick_count;

  logic                          frame_active_next;
  logic [irpd_pkg::BitPosW-1:0]  bit_position_next;
  logic [irpd_pkg::CountW-1:0]   byte_count_next;
  logic [irpd_pkg::ByteW-1:0]    shift_byte_next;
  logic [irpd_pkg::ByteW-1:0]    address_hold_next;
  logic [irpd_pkg::ByteW-1:0]    command_hold_next;
  logic [irpd_pkg::StampW-1:0]   last_stamp_next;
  logic [irpd_pkg::TickW-1:0]    tick_count_next;

  // output stage: main register and skid entry
  logic                out_valid;
  irpd_pkg::result_t   out_data;
  logic                skid_valid;
  irpd_pkg::result_t   skid_data;

  logic                in_fire;
  logic                out_fire;
  logic                emit;
  irpd_pkg::result_t   result;
  irpd_pkg::item_kind_t kind;

  logic [irpd_pkg::StampW-1:0] gap;
  logic                        gap_is_one;
  logic [irpd_pkg::ByteW-1:0]  shift_set;

  assign kind     = irpd_pkg::item_kind_t'(s_axis_tuser);
  // only the skid entry being full stops the input
  assign s_axis_tready = !skid_valid;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = out_valid && m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // gap wraps modulo 256 with the timer
  assign gap        = s_axis_tdata - last_stamp;
  assign gap_is_one = (gap >= one_gap_min) && (gap <= one_gap_max);
  assign shift_set  = shift_byte |
                      (gap_is_one ? (irpd_pkg::ByteW'(1) << bit_position) : '0);

  always_comb begin
    frame_active_next = frame_active;
    bit_position_next = bit_position;
    byte_count_next   = byte_count;
    shift_byte_next   = shift_byte;
    address_hold_next = address_hold;
    command_hold_next = command_hold;
    last_stamp_next   = last_stamp;
    tick_count_next   = tick_count;
    emit              = 1'b0;

    result.pad           = '0;
    result.bytes_seen    = byte_count;
    result.frame_command = command_hold;
    result.frame_address = address_hold;

    if (in_fire) begin
      case (kind)
        irpd_pkg::KIND_EDGE: begin
          if (!frame_active) begin
            // frame start: stamp not recorded, shift byte and ticks kept
            frame_active_next = 1'b1;
            bit_position_next = '0;
            byte_count_next   = '0;
            address_hold_next = '0;
            command_hold_next = '0;
          end else begin
            if (gap < leader_gap_min) begin
              if (bit_position == irpd_pkg::BitLast) begin
                if (byte_count == irpd_pkg::AddrByte) begin
                  address_hold_next = shift_set;
                end else if (byte_count == irpd_pkg::CmdByte) begin
                  command_hold_next = shift_set;
                end
                if (byte_count < irpd_pkg::ByteSat) begin
                  byte_count_next = byte_count + 1'b1;
                end
                bit_position_next = '0;
                shift_byte_next   = '0;
              end else begin
                shift_byte_next   = shift_set;
                bit_position_next = bit_position + 1'b1;
              end
            end
            last_stamp_next = s_axis_tdata;
          end
        end
        irpd_pkg::KIND_TICK: begin
          if (frame_active) begin
            if (tick_count < timeout_ticks) begin
              tick_count_next = tick_count + 1'b1;
            end else begin
              // timeout: close the frame, holds stay until the next start
              emit              = 1'b1;
              frame_active_next = 1'b0;
              bit_position_next = '0;
              shift_byte_next   = '0;
              last_stamp_next   = '0;
              tick_count_next   = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      one_gap_min    <= irpd_pkg::OneGapMinRst;
      one_gap_max    <= irpd_pkg::OneGapMaxRst;
      leader_gap_min <= irpd_pkg::LeaderGapMinRst;
      timeout_ticks  <= irpd_pkg::TimeoutTicksRst;
    end else if (cfg_we) begin
      case (irpd_pkg::cfg_index_t'(cfg_index))
        irpd_pkg::CFG_ONE_GAP_MIN:    one_gap_min    <= cfg_data;
        irpd_pkg::CFG_ONE_GAP_MAX:    one_gap_max    <= cfg_data;
        irpd_pkg::CFG_LEADER_GAP_MIN: leader_gap_min <= cfg_data;
        irpd_pkg::CFG_TIMEOUT_TICKS:  timeout_ticks  <= cfg_data[irpd_pkg::TickW-1:0];
        default: begin
        end
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active <= 1'b0;
      bit_position <= '0;
      byte_count   <= '0;
      shift_byte   <= '0;
      address_hold <= '0;
      command_hold <= '0;
      last_stamp   <= '0;
      tick_count   <= '0;
    end else begin
      frame_active <= frame_active_next;
      bit_position <= bit_position_next;
      byte_count   <= byte_count_next;
      shift_byte   <= shift_byte_next;
      address_hold <= address_hold_next;
      command_hold <= command_hold_next;
      last_stamp   <= last_stamp_next;
      tick_count   <= tick_count_next;
    end
  end

  // output register with skid: a new result goes straight out when the
  // main slot is empty or frees this cycle, else it parks in the skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_fire) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else if (emit) begin
          out_valid <= 1'b1;
          out_data  <= result;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (emit) begin
        skid_valid <= 1'b1;
        skid_data  <= result;
      end
    end
  end

  `include "ir_pulse_distance_decoder_assert.svh"

  `IRPD_ASSERT_ALWAYS(a_skid_behind_out, skid_valid |-> out_valid, "skid entry full while output empty")
  `IRPD_ASSERT_ALWAYS(a_idle_counters_clear, !frame_active |-> (bit_position == '0 && tick_count == '0 && last_stamp == '0), "counters not clear outside a frame")
  `IRPD_ASSERT_CLK(a_close_ends_frame, emit |=> (!frame_active && (out_valid || skid_valid)), "closing tick left frame open or lost the result")
  `IRPD_ASSERT_CLK(a_bytes_saturate, out_valid |-> (out_data.bytes_seen <= irpd_pkg::ByteSat), "byte count above saturation")

endmodule
